// File: rtl/core/drum_step_sequencer_assert.svh
// Assertion macros used by the sequencer RTL.
// Each macro checks one property on the rising clock edge, outside reset.
`ifndef DRUM_STEP_SEQUENCER_ASSERT_SVH
`define DRUM_STEP_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dss_pkg.sv
package dss_pkg;

  // Event codes on the input channel.
  localparam logic [3:0] FUNC_TICK    = 4'd0;
  localparam logic [3:0] FUNC_PRESS   = 4'd1;
  localparam logic [3:0] FUNC_RELEASE = 4'd2;
  localparam logic [3:0] FUNC_NEXT    = 4'd3;
  localparam logic [3:0] FUNC_PREV    = 4'd4;
  localparam logic [3:0] FUNC_DONE    = 4'd5;
  localparam logic [3:0] FUNC_PLAY    = 4'd6;
  localparam logic [3:0] FUNC_UP      = 4'd7;
  localparam logic [3:0] FUNC_DOWN    = 4'd8;

  // Operating modes.
  localparam logic [1:0] MODE_LIVE  = 2'd0;
  localparam logic [1:0] MODE_PEDIT = 2'd1;
  localparam logic [1:0] MODE_IEDIT = 2'd2;
  localparam logic [1:0] MODE_MUTE  = 2'd3;

  // Result word kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_OFF    = 2'd1;
  localparam logic [1:0] KIND_ON     = 2'd2;

  localparam logic [8:0] TEMPO_MAX      = 9'd300;
  localparam logic [8:0] TEMPO_RESET    = 9'd200;
  localparam logic [8:0] BPM_STEP_RESET = 9'd10;
  localparam logic [7:0] PAT0_RESET     = 8'h15;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] instrument;
    logic [1:0] mode;
    logic [2:0] step;
    logic       paused;
    logic       editing;
    logic [8:0] tempo;
    logic [7:0] leds;
    logic       leds_animated;
    logic       last;
  } res_t;

  // Pattern of an instrument right after reset.
  function automatic logic [7:0] pat_reset(logic [2:0] inst);
    return (inst == 3'd0) ? PAT0_RESET : 8'h00;
  endfunction

endpackage

// File: rtl/core/dss_ifs.sv
// Event channel into the sequencer.
interface dss_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [2:0] button;

  modport source (output valid, output func, output button, input ready);
  modport sink (input valid, input func, input button, output ready);
endinterface

// Result channel out of the sequencer.
interface dss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] instrument;
  logic [1:0] mode;
  logic [2:0] step;
  logic       paused;
  logic       editing;
  logic [8:0] tempo;
  logic [7:0] leds;
  logic       leds_animated;
  logic       last;

  modport source (output valid, output kind, output instrument, output mode, output step,
                  output paused, output editing, output tempo, output leds,
                  output leds_animated, output last, input ready);
  modport sink (input valid, input kind, input instrument, input mode, input step,
                input paused, input editing, input tempo, input leds,
                input leds_animated, input last, output ready);
endinterface

// Configuration write channel for the tempo increment.
interface dss_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] bpm_step;

  modport source (output valid, output bpm_step, input ready);
  modport sink (input valid, input bpm_step, output ready);
endinterface

// File: rtl/core/dss_pat_mem.sv
module dss_pat_mem
  import dss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [2:0] wr_addr_i,
  input  logic [7:0] wr_data_i,
  input  logic       rd_en_i,
  input  logic [2:0] rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem [8];
  logic [7:0] wr_valid_q;
  logic [7:0] rd_data_q;

  // Storage array; written only, never reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Written flags, so that untouched rows read as their reset pattern.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= '0;
    end else if (wr_en_i) begin
      wr_valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= wr_valid_q[rd_addr_i] ? mem[rd_addr_i] : pat_reset(rd_addr_i);
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/drum_step_sequencer.sv
// Non-tick events go to S_STATUS, through S_LOAD or S_TOG first when a row is read; the word
// is then registered in the output register, once that is free. A paused tick is a status event.
// A playing tick sweeps the 8 pattern rows (S_SRD then S_SCHK per row, one memory read port),
// then pushes 2 words per sounding instrument, or one status word if none sounds.
// One event is in flight; the next is accepted once its last word is in the output register.
// Reset initialises all control state; pattern rows read as their reset value until first written.
`include "drum_step_sequencer_assert.svh"

module drum_step_sequencer
  import dss_pkg::*;
#(
  parameter int STEPS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dss_cfg_if.sink   cfg_ch,
  dss_in_if.sink    in_ch,
  dss_out_if.source out_ch
);

  localparam int SW = $clog2(STEPS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCHK   = 4'd2;
  localparam logic [3:0] S_PREP   = 4'd3;
  localparam logic [3:0] S_OFF    = 4'd4;
  localparam logic [3:0] S_ON     = 4'd5;
  localparam logic [3:0] S_LOAD   = 4'd6;
  localparam logic [3:0] S_TOG    = 4'd7;
  localparam logic [3:0] S_STATUS = 4'd8;

  // Maps a step position to a pattern bit index: {in range, bit}.
  function automatic logic [3:0] bit_idx(logic [4:0] pos);
    logic [5:0] diff;
    diff = 6'(STEPS - 1) - {1'b0, pos};
    return {(!diff[5] && (diff[4:3] == 2'b00)), diff[2:0]};
  endfunction

  function automatic logic pat_bit(logic [7:0] row, logic [4:0] pos);
    logic [3:0] bi;
    bi = bit_idx(pos);
    return bi[3] && row[bi[2:0]];
  endfunction

  logic [3:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [1:0]    mode_q, mode_d;
  logic          paused_q, paused_d;
  logic          chosen_q, chosen_d;
  logic [2:0]    chosen_idx_q, chosen_idx_d;
  logic [8:0]    tempo_q, tempo_d;
  logic [7:0]    held_q, held_d;
  logic [7:0]    muted_q, muted_d;
  logic [7:0]    col_q, col_d;
  logic [7:0]    row_q, row_d;
  logic [7:0]    pend_q, pend_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [1:0]    res_kind_q, res_kind_d;
  logic [2:0]    res_inst_q, res_inst_d;
  logic          tog_ok_q, tog_ok_d;
  logic [2:0]    tog_bit_q, tog_bit_d;
  logic [8:0]    bpm_q;
  logic          ov_q;
  res_t          out_q;

  logic          in_acc;
  logic          push_ok;
  logic          push;
  res_t          push_word;
  logic [1:0]    push_kind;
  logic [2:0]    push_inst;
  logic          push_last;
  logic [2:0]    cur_inst;
  logic [7:0]    cur_mask;
  logic [4:0]    step5;
  logic [7:0]    step_led;
  logic [7:0]    leds;
  logic          anim;
  logic [9:0]    tempo_sum;
  logic [3:0]    btn_idx;
  logic [7:0]    new_row;

  logic          mem_rd_en;
  logic [2:0]    mem_rd_addr;
  logic          mem_wr_en;
  logic [7:0]    mem_rd_data;

  dss_pat_mem u_pat_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (chosen_idx_q),
    .wr_data_i (new_row),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign in_ch.ready  = (state_q == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign push_ok      = !ov_q || out_ch.ready;

  assign step5     = 5'(step_q);
  assign step_led  = (step5 < 5'd8) ? (8'd1 << step5[2:0]) : 8'h00;
  assign tempo_sum = {1'b0, tempo_q} + {1'b0, bpm_q};
  assign btn_idx   = bit_idx({2'b00, in_ch.button});
  assign new_row   = mem_rd_data ^ (8'd1 << tog_bit_q);

  // Lowest pending instrument of a tick.
  always_comb begin
    cur_inst = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_q[i]) begin
        cur_inst = 3'(i);
      end
    end
    cur_mask = 8'd1 << cur_inst;
  end

  // LED word and animation flag from the current state.
  always_comb begin
    leds = 8'h00;
    anim = 1'b0;
    case (mode_q)
      MODE_LIVE: begin
        leds = step_led | held_q;
      end
      MODE_PEDIT: begin
        if (!chosen_q) begin
          anim = 1'b1;
        end else begin
          for (int i = 0; i < 8; i++) begin
            leds[i] = pat_bit(row_q, 5'(i));
          end
          leds = leds | step_led;
        end
      end
      MODE_IEDIT: begin
        if (!chosen_q) begin
          anim = 1'b1;
        end else begin
          leds = 8'd1 << chosen_idx_q;
        end
      end
      default: begin
        leds = muted_q | col_q;
      end
    endcase
  end

  // Result word assembled from the state after the event.
  always_comb begin
    push_word.kind          = push_kind;
    push_word.instrument    = push_inst;
    push_word.mode          = mode_q;
    push_word.step          = step5[2:0];
    push_word.paused        = paused_q;
    push_word.editing       = chosen_q;
    push_word.tempo         = tempo_q;
    push_word.leds          = leds;
    push_word.leds_animated = anim;
    push_word.last          = push_last;
  end

  // Event decode and sequencing over the pattern memory.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    mode_d       = mode_q;
    paused_d     = paused_q;
    chosen_d     = chosen_q;
    chosen_idx_d = chosen_idx_q;
    tempo_d      = tempo_q;
    held_d       = held_q;
    muted_d      = muted_q;
    col_d        = col_q;
    row_d        = row_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    res_kind_d   = res_kind_q;
    res_inst_d   = res_inst_q;
    tog_ok_d     = tog_ok_q;
    tog_bit_d    = tog_bit_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = cnt_q;
    mem_wr_en    = 1'b0;
    push         = 1'b0;
    push_kind    = res_kind_q;
    push_inst    = res_inst_q;
    push_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_kind_d = KIND_STATUS;
          res_inst_d = 3'd0;
          state_d    = S_STATUS;
          case (in_ch.func)
            FUNC_TICK: begin
              if (!paused_q) begin
                step_d  = (step_q == SW'(STEPS - 1)) ? '0 : step_q + SW'(1);
                cnt_d   = 3'd0;
                state_d = S_SRD;
              end
            end
            FUNC_PRESS: begin
              held_d = held_q | (8'd1 << in_ch.button);
              case (mode_q)
                MODE_LIVE: begin
                  res_kind_d = KIND_ON;
                  res_inst_d = in_ch.button;
                end
                MODE_PEDIT, MODE_IEDIT: begin
                  if (!chosen_q) begin
                    chosen_d     = 1'b1;
                    chosen_idx_d = in_ch.button;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = in_ch.button;
                    state_d      = S_LOAD;
                  end else if (mode_q == MODE_PEDIT) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = chosen_idx_q;
                    tog_ok_d    = btn_idx[3];
                    tog_bit_d   = btn_idx[2:0];
                    state_d     = S_TOG;
                  end
                end
                default: begin
                  muted_d[in_ch.button] = !muted_q[in_ch.button];
                end
              endcase
            end
            FUNC_RELEASE: begin
              held_d = held_q & ~(8'd1 << in_ch.button);
              if (mode_q == MODE_LIVE) begin
                res_kind_d = KIND_OFF;
                res_inst_d = in_ch.button;
              end
            end
            FUNC_NEXT: begin
              if (!chosen_q) begin
                mode_d = mode_q + 2'd1;
              end
            end
            FUNC_PREV: begin
              if (!chosen_q) begin
                mode_d = mode_q - 2'd1;
              end
            end
            FUNC_DONE: begin
              if (mode_q inside {MODE_PEDIT, MODE_IEDIT}) begin
                chosen_d = 1'b0;
              end
            end
            FUNC_PLAY: begin
              paused_d = !paused_q;
            end
            FUNC_UP: begin
              tempo_d = (tempo_sum > {1'b0, TEMPO_MAX}) ? TEMPO_MAX : tempo_sum[8:0];
            end
            FUNC_DOWN: begin
              tempo_d = (tempo_q < bpm_q) ? 9'd0 : tempo_q - bpm_q;
            end
            default: begin
            end
          endcase
        end
      end
      // Sweep: read each row, then record its bit at the new step.
      S_SRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_q;
        state_d     = S_SCHK;
      end
      S_SCHK: begin
        col_d[cnt_q] = pat_bit(mem_rd_data, step5);
        if (cnt_q == 3'd7) begin
          state_d = S_PREP;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = S_SRD;
        end
      end
      S_PREP: begin
        pend_d  = col_q & ~muted_q;
        state_d = S_OFF;
      end
      S_OFF: begin
        if (pend_q == 8'h00) begin
          state_d = S_STATUS;
        end else if (push_ok) begin
          push      = 1'b1;
          push_kind = KIND_OFF;
          push_inst = cur_inst;
          push_last = 1'b0;
          state_d   = S_ON;
        end
      end
      S_ON: begin
        push_kind = KIND_ON;
        push_inst = cur_inst;
        push_last = ((pend_q & ~cur_mask) == 8'h00);
        if (push_ok) begin
          push    = 1'b1;
          pend_d  = pend_q & ~cur_mask;
          state_d = push_last ? S_IDLE : S_OFF;
        end
      end
      S_LOAD: begin
        row_d   = mem_rd_data;
        state_d = S_STATUS;
      end
      // Read-modify-write of the chosen instrument's row.
      S_TOG: begin
        if (tog_ok_q) begin
          mem_wr_en           = 1'b1;
          row_d               = new_row;
          col_d[chosen_idx_q] = pat_bit(new_row, step5);
        end
        state_d = S_STATUS;
      end
      S_STATUS: begin
        if (push_ok) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= SW'(STEPS - 1);
      mode_q       <= MODE_LIVE;
      paused_q     <= 1'b0;
      chosen_q     <= 1'b0;
      chosen_idx_q <= 3'd0;
      tempo_q      <= TEMPO_RESET;
      held_q       <= 8'h00;
      muted_q      <= 8'h00;
      // At the last step every row shows bit zero of its reset pattern.
      col_q        <= {7'd0, PAT0_RESET[0]};
      cnt_q        <= 3'd0;
      pend_q       <= 8'h00;
      bpm_q        <= BPM_STEP_RESET;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      mode_q       <= mode_d;
      paused_q     <= paused_d;
      chosen_q     <= chosen_d;
      chosen_idx_q <= chosen_idx_d;
      tempo_q      <= tempo_d;
      held_q       <= held_d;
      muted_q      <= muted_d;
      col_q        <= col_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        bpm_q <= cfg_ch.bpm_step;
      end
      if (push) begin
        ov_q <= 1'b1;
      end else if (out_ch.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    res_kind_q <= res_kind_d;
    res_inst_q <= res_inst_d;
    tog_ok_q   <= tog_ok_d;
    tog_bit_q  <= tog_bit_d;
    if (push) begin
      out_q <= push_word;
    end
  end

  assign out_ch.valid         = ov_q;
  assign out_ch.kind          = out_q.kind;
  assign out_ch.instrument    = out_q.instrument;
  assign out_ch.mode          = out_q.mode;
  assign out_ch.step          = out_q.step;
  assign out_ch.paused        = out_q.paused;
  assign out_ch.editing       = out_q.editing;
  assign out_ch.tempo         = out_q.tempo;
  assign out_ch.leds          = out_q.leds;
  assign out_ch.leds_animated = out_q.leds_animated;
  assign out_ch.last          = out_q.last;

  `DSS_ASSERT_IMPLY(a_tempo_range, 1'b1, tempo_q <= TEMPO_MAX, "tempo above maximum")
  `DSS_ASSERT_IMPLY(a_mem_no_overlap, mem_wr_en, !mem_rd_en, "pattern read during write")
  `DSS_ASSERT_NEXT(a_last_to_idle, push && push_last, state_q == S_IDLE, "last word not idle")
  `DSS_ASSERT_NEXT(a_off_then_on, push && (state_q == S_OFF), state_q == S_ON, "note on lost")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dss_pkg::*;

  localparam int STEPS = 8;

  // One pad or control event waiting to go out on the event channel.
  typedef struct packed {
    logic [3:0] func;
    logic [2:0] button;
  } pad_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [3:0] in_func = FUNC_TICK;
  logic [2:0] in_button = 3'd0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [8:0] cfg_data = 9'd0;

  dss_in_if  in_ch ();
  dss_out_if out_ch ();
  dss_cfg_if cfg_ch ();

  assign in_ch.valid     = in_valid;
  assign in_ch.func      = in_func;
  assign in_ch.button    = in_button;
  assign out_ch.ready    = out_ready;
  assign cfg_ch.valid    = cfg_valid;
  assign cfg_ch.bpm_step = cfg_data;

  drum_step_sequencer #(
    .STEPS(STEPS)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sequencer state as this bench expects it to be.
  logic [7:0] rows [8];
  logic [7:0] mute_mask;
  logic [1:0] mode_q;
  int         step_q;
  logic       paused_q;
  logic       chosen_q;
  logic [2:0] chosen_idx;
  int         tempo_q;
  logic [7:0] held_q;
  int         tempo_inc;

  res_t       owed_words [$];
  pad_event_t pending_events [$];
  res_t       seen_word;
  res_t       due_word;
  int         fail_count = 0;
  bit         in_took = 1'b0;
  bit         idle_on = 1'b1;
  int         idle_odds = 6;
  int         in_gap = 0;
  int         out_gap = 0;

  task automatic reset_model();
    int i;
    for (i = 0; i < 8; i++) begin
      rows[i] = 8'h00;
    end
    rows[0]    = PAT0_RESET;
    mute_mask  = 8'h00;
    mode_q     = MODE_LIVE;
    step_q     = STEPS - 1;
    paused_q   = 1'b0;
    chosen_q   = 1'b0;
    chosen_idx = 3'd0;
    tempo_q    = TEMPO_RESET;
    held_q     = 8'h00;
    tempo_inc  = BPM_STEP_RESET;
  endtask

  // Patterns are read MSB first; positions past the row width read as silent.
  function automatic bit row_bit(int inst, int pos);
    int idx;
    idx = STEPS - 1 - pos;
    if (idx < 0 || idx > 7) return 1'b0;
    return rows[inst][idx];
  endfunction

  function automatic logic [7:0] step_lamp();
    return (step_q < 8) ? 8'(1 << step_q) : 8'h00;
  endfunction

  // Builds one result word from the current state, LED word included.
  function automatic res_t make_word(logic [1:0] kind, logic [2:0] inst);
    res_t       w;
    logic [7:0] lamps;
    int         i;
    w     = '0;
    lamps = 8'h00;
    case (mode_q)
      MODE_LIVE: begin
        lamps = step_lamp() | held_q;
      end
      MODE_PEDIT: begin
        if (!chosen_q) begin
          w.leds_animated = 1'b1;
        end else begin
          for (i = 0; i < 8; i++) begin
            if (row_bit(chosen_idx, i)) lamps[i] = 1'b1;
          end
          lamps = lamps | step_lamp();
        end
      end
      MODE_IEDIT: begin
        if (!chosen_q) w.leds_animated = 1'b1;
        else lamps[chosen_idx] = 1'b1;
      end
      default: begin
        for (i = 0; i < 8; i++) begin
          if (mute_mask[i] || row_bit(i, step_q)) lamps[i] = 1'b1;
        end
      end
    endcase
    w.kind       = kind;
    w.instrument = inst;
    w.mode       = mode_q;
    w.step       = 3'(step_q);
    w.paused     = paused_q;
    w.editing    = chosen_q;
    w.tempo      = 9'(tempo_q);
    w.leds       = lamps;
    return w;
  endfunction

  // Applies one accepted event to the state and queues the words it should cause.
  task automatic apply_event(logic [3:0] func, logic [2:0] btn);
    int   i;
    int   idx;
    int   n;
    res_t w;
    n = 0;
    case (func)
      FUNC_TICK: begin
        if (!paused_q) begin
          step_q = (step_q + 1) % STEPS;
          for (i = 0; i < 8; i++) begin
            if (!mute_mask[i] && row_bit(i, step_q)) begin
              owed_words.push_back(make_word(KIND_OFF, 3'(i)));
              owed_words.push_back(make_word(KIND_ON, 3'(i)));
              n += 2;
            end
          end
        end
      end
      FUNC_PRESS: begin
        held_q[btn] = 1'b1;
        if (mode_q == MODE_LIVE) begin
          owed_words.push_back(make_word(KIND_ON, btn));
          n++;
        end else if (mode_q == MODE_PEDIT) begin
          if (!chosen_q) begin
            chosen_q   = 1'b1;
            chosen_idx = btn;
          end else begin
            idx = STEPS - 1 - int'(btn);
            if (idx >= 0 && idx <= 7) rows[chosen_idx][idx] = ~rows[chosen_idx][idx];
          end
        end else if (mode_q == MODE_IEDIT) begin
          if (!chosen_q) begin
            chosen_q   = 1'b1;
            chosen_idx = btn;
          end
        end else begin
          mute_mask[btn] = ~mute_mask[btn];
        end
      end
      FUNC_RELEASE: begin
        held_q[btn] = 1'b0;
        if (mode_q == MODE_LIVE) begin
          owed_words.push_back(make_word(KIND_OFF, btn));
          n++;
        end
      end
      FUNC_NEXT: begin
        if (!chosen_q) mode_q = mode_q + 2'd1;
      end
      FUNC_PREV: begin
        if (!chosen_q) mode_q = mode_q - 2'd1;
      end
      FUNC_DONE: begin
        if (mode_q == MODE_PEDIT || mode_q == MODE_IEDIT) chosen_q = 1'b0;
      end
      FUNC_PLAY: begin
        paused_q = ~paused_q;
      end
      FUNC_UP: begin
        if (tempo_q + tempo_inc > int'(TEMPO_MAX)) tempo_q = TEMPO_MAX;
        else tempo_q = tempo_q + tempo_inc;
      end
      FUNC_DOWN: begin
        if (tempo_q < tempo_inc) tempo_q = 0;
        else tempo_q = tempo_q - tempo_inc;
      end
      default: ;
    endcase
    // Events that sound nothing report status once; the final word is flagged.
    if (n == 0) owed_words.push_back(make_word(KIND_STATUS, 3'd0));
    w      = owed_words.pop_back();
    w.last = 1'b1;
    owed_words.push_back(w);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Monitor: checks result words, then tracks accepted events and register writes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen_word.kind          = out_ch.kind;
        seen_word.instrument    = out_ch.instrument;
        seen_word.mode          = out_ch.mode;
        seen_word.step          = out_ch.step;
        seen_word.paused        = out_ch.paused;
        seen_word.editing       = out_ch.editing;
        seen_word.tempo         = out_ch.tempo;
        seen_word.leds          = out_ch.leds;
        seen_word.leds_animated = out_ch.leds_animated;
        seen_word.last          = out_ch.last;
        if (owed_words.size() == 0) begin
          fail_count++;
          $display("%0t: expected no word, got kind %0d instrument %0d", $time,
                   seen_word.kind, seen_word.instrument);
        end else begin
          due_word = owed_words.pop_front();
          check_field("kind", due_word.kind, seen_word.kind);
          check_field("instrument", due_word.instrument, seen_word.instrument);
          check_field("mode", due_word.mode, seen_word.mode);
          check_field("step", due_word.step, seen_word.step);
          check_field("paused", due_word.paused, seen_word.paused);
          check_field("editing", due_word.editing, seen_word.editing);
          check_field("tempo", due_word.tempo, seen_word.tempo);
          check_field("leds", due_word.leds, seen_word.leds);
          check_field("leds_animated", due_word.leds_animated, seen_word.leds_animated);
          check_field("last", due_word.last, seen_word.last);
        end
      end
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) apply_event(in_ch.func, in_ch.button);
      if (cfg_ch.valid && cfg_ch.ready) tempo_inc = cfg_ch.bpm_step;
    end
  end

  // Event driver: holds a word until taken, otherwise idles in bursts or sends the next one.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, idle_odds) == 0) begin
        in_gap = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        pad_event_t ev;
        ev = pending_events.pop_front();
        in_valid  <= 1'b1;
        in_func   <= ev.func;
        in_button <= ev.button;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: stalls in random bursts while idling is on.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, idle_odds) == 0) begin
      out_gap = $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_event(logic [3:0] func, logic [2:0] btn);
    pad_event_t ev;
    ev.func   = func;
    ev.button = btn;
    pending_events.push_back(ev);
  endtask

  // Ticks and pad presses most often, with the occasional full edit session mixed in.
  task automatic queue_random(int count);
    int k;
    int r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        queue_event(FUNC_NEXT, 3'($urandom_range(0, 7)));
        queue_event(FUNC_PRESS, 3'($urandom_range(0, 7)));
        repeat ($urandom_range(1, 4)) queue_event(FUNC_PRESS, 3'($urandom_range(0, 7)));
        queue_event(FUNC_DONE, 3'($urandom_range(0, 7)));
        queue_event(FUNC_TICK, 3'($urandom_range(0, 7)));
      end else if (r < 40) queue_event(FUNC_TICK, 3'($urandom_range(0, 7)));
      else if (r < 56) queue_event(FUNC_PRESS, 3'($urandom_range(0, 7)));
      else if (r < 64) queue_event(FUNC_RELEASE, 3'($urandom_range(0, 7)));
      else if (r < 71) queue_event(FUNC_NEXT, 3'($urandom_range(0, 7)));
      else if (r < 76) queue_event(FUNC_PREV, 3'($urandom_range(0, 7)));
      else if (r < 82) queue_event(FUNC_DONE, 3'($urandom_range(0, 7)));
      else if (r < 86) queue_event(FUNC_PLAY, 3'($urandom_range(0, 7)));
      else if (r < 91) queue_event(FUNC_UP, 3'($urandom_range(0, 7)));
      else if (r < 96) queue_event(FUNC_DOWN, 3'($urandom_range(0, 7)));
      else queue_event(4'($urandom_range(9, 15)), 3'($urandom_range(0, 7)));
    end
  endtask

  // Waits until every queued event went out and every word came back, then lets the block settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_events.size() != 0 || in_valid || owed_words.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_step(logic [8:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: a directed walk through every mode, then random phases per tempo step.
  initial begin
    int step_values [5];
    int phase;
    step_values = '{300, 0, 255, 1, 0};
    step_values[4] = $urandom_range(0, 300);
    reset_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Ticks from reset, the first pattern hit lands on the fourth one.
    repeat (4) queue_event(FUNC_TICK, 3'd0);
    // Live pads light and sound.
    queue_event(FUNC_PRESS, 3'd0);
    queue_event(FUNC_PRESS, 3'd7);
    queue_event(FUNC_RELEASE, 3'd7);
    queue_event(FUNC_RELEASE, 3'd0);
    // A paused tick reports status only.
    queue_event(FUNC_PLAY, 3'd0);
    queue_event(FUNC_TICK, 3'd0);
    queue_event(FUNC_PLAY, 3'd0);
    // Pattern editor: choose, toggle both end bits, mode change blocked while editing.
    queue_event(FUNC_NEXT, 3'd0);
    queue_event(FUNC_PRESS, 3'd7);
    queue_event(FUNC_PRESS, 3'd0);
    queue_event(FUNC_PRESS, 3'd7);
    queue_event(FUNC_NEXT, 3'd0);
    queue_event(FUNC_DONE, 3'd0);
    // Instrument editor ignores a second press once a choice is made.
    queue_event(FUNC_NEXT, 3'd0);
    queue_event(FUNC_PRESS, 3'd2);
    queue_event(FUNC_PRESS, 3'd3);
    queue_event(FUNC_DONE, 3'd0);
    // Mute a pad, then play it live anyway.
    queue_event(FUNC_NEXT, 3'd0);
    queue_event(FUNC_PRESS, 3'd7);
    queue_event(FUNC_NEXT, 3'd0);
    queue_event(FUNC_PRESS, 3'd7);
    queue_event(FUNC_RELEASE, 3'd7);
    // Unused event codes.
    queue_event(4'd15, 3'd5);
    queue_random(20);
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      if (phase == 4) idle_on = 1'b0;
      else idle_odds = $urandom_range(2, 20);
      write_step(9'(step_values[phase]));
      // Tempo saturation at both ends.
      queue_event(FUNC_UP, 3'd0);
      queue_event(FUNC_DOWN, 3'd0);
      queue_event(FUNC_DOWN, 3'd0);
      queue_event(FUNC_PREV, 3'd0);
      queue_event(FUNC_UP, 3'd0);
      queue_random(11);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/dss_pkg.sv
rtl/core/dss_ifs.sv
rtl/core/dss_pat_mem.sv
rtl/core/drum_step_sequencer.sv
tb/testbench.sv
